/* rtl/two_opt_best_move_search_unit_assert.svh */
// Assertion macros for the 2-opt search unit; they sample on clk_i and
// are disabled while rst_ni is low.
`ifndef TWO_OPT_BEST_MOVE_SEARCH_UNIT_ASSERT_SVH
`define TWO_OPT_BEST_MOVE_SEARCH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TOPT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`define TOPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define TOPT_ASSERT_ALWAYS(lbl, cond, msg)
`define TOPT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

/* rtl/topt_pkg.sv */
`timescale 1ns / 1ps
package topt_pkg;

  localparam int unsigned CITY_W     = 4;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned EDGE_W     = 16;
  localparam int unsigned DELTA_W    = 18;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR_COST = 2'd0,
    FUNC_WR_TOUR = 2'd1,
    FUNC_RUN     = 2'd2,
    FUNC_RD_TOUR = 2'd3
  } func_e;

  typedef enum logic {
    KIND_RUN  = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  // request payload, last field in the low bits
  typedef struct packed {
    logic [CITY_W-1:0] city_in;
    logic [POS_W-1:0]  position;
    logic [EDGE_W-1:0] edge_cost;
    logic [CITY_W-1:0] to_city;
    logic [CITY_W-1:0] from_city;
  } in_data_t;

  typedef struct packed {
    logic               pad;
    logic               applied;
    logic [POS_W-1:0]   move_end;
    logic [POS_W-1:0]   move_start;
    logic [DELTA_W-1:0] best_delta;
    logic [CITY_W-1:0]  city_out;
  } out_data_t;

endpackage

/* rtl/topt_ram.sv */
`timescale 1ns / 1ps
module topt_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/two_opt_best_move_search_unit.sv */
// 2-opt best-move search over a tour held on chip.
// Requests come in on s_axis: tuser carries the function code, tdata the
// cost-entry, position and city fields. Cost writes and tour writes give no
// result. A tour read returns one result through ST_RD, ST_DONE and the
// output register. A run request scans every segment [s,e] with
// 1 <= s < e <= len-2, keeps the first smallest 2-opt delta and reverses the
// winning segment when that delta is negative, then sends one report.
// A run scans the segments one at a time, then reverses the winning segment
// one swapped pair at a time when the move is applied, then hands off the
// report. Segments are handled in turn because every cost read and every
// add, subtract and compare goes through one cost-memory read port and one
// shared adder in turn.
// s_axis_tready_o is high only while the sequencer is idle; writes are taken
// even while a result waits in the output register. If m_axis stalls, a
// finished run or read waits in the sequencer until the output frees up.
// The tour length register is written on the cfg channel, always ready.
// Reset clears the sequencer, empties the output and sets tour length to 16;
// cost and tour memories are not cleared and must be loaded before use.
`timescale 1ns / 1ps
`include "two_opt_best_move_search_unit_assert.svh"
module two_opt_best_move_search_unit #(
  parameter int unsigned MAX_CITIES = 16,
  parameter int unsigned COST_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // cfg: tour_len
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [topt_pkg::LEN_W-1:0]         cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // from_city, to_city, edge_cost, position, city_in
  input  logic [topt_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // func
  input  logic [topt_pkg::FUNC_W-1:0]        s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // city_out, best_delta, move_start, move_end, applied, zero pad
  output logic [topt_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // kind
  output logic [0:0]                         m_axis_tuser_o
);

  import topt_pkg::*;

  localparam int unsigned PW    = $clog2(MAX_CITIES);
  localparam int unsigned LW    = $clog2(MAX_CITIES + 1);
  localparam int unsigned CDEP  = MAX_CITIES * MAX_CITIES;
  localparam int unsigned CAW   = $clog2(CDEP);
  localparam int unsigned DW    = COST_BITS + 2;
  localparam int unsigned UW    = DW + 1;
  localparam int unsigned CW1   = CITY_W + 1;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_RD     = 5'd1;
  localparam logic [4:0] ST_RUN    = 5'd2;
  localparam logic [4:0] ST_S_H    = 5'd3;
  localparam logic [4:0] ST_S_I    = 5'd4;
  localparam logic [4:0] ST_S_J    = 5'd5;
  localparam logic [4:0] ST_S_CHI  = 5'd6;
  localparam logic [4:0] ST_E_L    = 5'd7;
  localparam logic [4:0] ST_E_HJ   = 5'd8;
  localparam logic [4:0] ST_E_IL   = 5'd9;
  localparam logic [4:0] ST_E_JL   = 5'd10;
  localparam logic [4:0] ST_E_SUB1 = 5'd11;
  localparam logic [4:0] ST_E_SUB2 = 5'd12;
  localparam logic [4:0] ST_E_CMP  = 5'd13;
  localparam logic [4:0] ST_REV_A  = 5'd14;
  localparam logic [4:0] ST_REV_B  = 5'd15;
  localparam logic [4:0] ST_REV_WA = 5'd16;
  localparam logic [4:0] ST_REV_WB = 5'd17;
  localparam logic [4:0] ST_DONE   = 5'd18;

  // city numbers and positions wrap at MAX_CITIES (at most four subtracts)
  function automatic logic [PW-1:0] wrap(input logic [CITY_W-1:0] v);
    logic [CW1-1:0] t;
    t = {1'b0, v};
    for (int k = 0; k < 4; k++) begin
      if (int'(t) >= MAX_CITIES) begin
        t = t - CW1'(MAX_CITIES);
      end
    end
    return PW'(t);
  endfunction

  function automatic logic [CAW-1:0] cost_addr(input logic [PW-1:0] r,
                                               input logic [PW-1:0] c);
    return CAW'(r) * CAW'(MAX_CITIES) + CAW'(c);
  endfunction

  logic [4:0]            state_q, state_d;
  logic [LEN_W-1:0]      tour_len_q;
  logic [LW-1:0]         len_q;
  logic [PW-1:0]         s_q, e_q, bs_q, be_q;
  logic [CITY_W-1:0]     h_q, i_q, j_q, l_q;
  logic [COST_BITS-1:0]  chi_q;
  logic signed [DW-1:0]  acc_q, best_q, best_nx;
  logic                  found_q, applied_q, win;
  kind_e                 res_kind_q, out_kind_q;
  logic [CITY_W-1:0]     res_city_q;
  logic                  out_valid_q, out_valid_d, out_load;
  out_data_t             out_data_q;

  in_data_t              in_data;
  func_e                 in_func;
  logic                  in_acc;
  logic                  more_e, more_s, more_rev;

  logic                  tour_we, cost_we;
  logic [PW-1:0]         tour_waddr, tour_raddr;
  logic [CITY_W-1:0]     tour_wdata, tour_rdata;
  logic [CAW-1:0]        cost_waddr, cost_raddr;
  logic [COST_BITS-1:0]  cost_rdata;

  logic signed [UW-1:0]  alu_a, alu_b, alu_y;
  logic [UW-1:0]         alu_b_eff;
  logic                  alu_sub;

  assign in_data         = s_axis_tdata_i;
  assign in_func         = func_e'(s_axis_tuser_i);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  assign more_e   = (LW'(e_q) + LW'(2)) < len_q;
  assign more_s   = (LW'(s_q) + LW'(3)) < len_q;
  assign more_rev = (LW'(s_q) + LW'(2)) < LW'(e_q);

  // ---------------- memories ----------------
  topt_ram #(
    .WIDTH (CITY_W),
    .DEPTH (MAX_CITIES)
  ) u_tour (
    .clk_i   (clk_i),
    .we_i    (tour_we),
    .waddr_i (tour_waddr),
    .wdata_i (tour_wdata),
    .raddr_i (tour_raddr),
    .rdata_o (tour_rdata)
  );

  topt_ram #(
    .WIDTH (COST_BITS),
    .DEPTH (CDEP)
  ) u_cost (
    .clk_i   (clk_i),
    .we_i    (cost_we),
    .waddr_i (cost_waddr),
    .wdata_i (COST_BITS'(in_data.edge_cost)),
    .raddr_i (cost_raddr),
    .rdata_o (cost_rdata)
  );

  assign cost_we    = in_acc && (in_func == FUNC_WR_COST);
  assign cost_waddr = cost_addr(wrap(in_data.from_city), wrap(in_data.to_city));

  always_comb begin
    tour_we    = 1'b0;
    tour_waddr = wrap(in_data.position);
    tour_wdata = in_data.city_in;
    tour_raddr = '0;
    cost_raddr = '0;
    unique case (state_q)
      ST_IDLE: begin
        tour_we    = in_acc && (in_func == FUNC_WR_TOUR);
        tour_raddr = wrap(in_data.position);
      end
      ST_S_H:   tour_raddr = s_q - PW'(1);
      ST_S_I:   tour_raddr = s_q;
      ST_S_J: begin
        tour_raddr = e_q;
        // i arrives now: fetch cost(h,i) straight off the read data
        cost_raddr = cost_addr(wrap(h_q), wrap(tour_rdata));
      end
      ST_E_L:   tour_raddr = e_q + PW'(1);
      ST_E_HJ:  cost_raddr = cost_addr(wrap(h_q), wrap(j_q));
      ST_E_IL:  cost_raddr = cost_addr(wrap(i_q), wrap(l_q));
      ST_E_JL:  cost_raddr = cost_addr(wrap(j_q), wrap(l_q));
      ST_REV_A: tour_raddr = s_q;
      ST_REV_B: tour_raddr = e_q;
      ST_REV_WA: begin
        tour_we    = 1'b1;
        tour_waddr = s_q;
        tour_wdata = tour_rdata;
      end
      ST_REV_WB: begin
        tour_we    = 1'b1;
        tour_waddr = e_q;
        tour_wdata = h_q;
      end
      default: ;
    endcase
  end

  // ---------------- shared adder ----------------
  always_comb begin
    alu_a   = UW'(acc_q);
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      ST_E_IL: begin
        alu_a = '0;
        alu_b = UW'(cost_rdata);
      end
      ST_E_JL:   alu_b = UW'(cost_rdata);
      ST_E_SUB1: begin
        alu_b   = UW'(cost_rdata);
        alu_sub = 1'b1;
      end
      ST_E_SUB2: begin
        alu_b   = UW'(chi_q);
        alu_sub = 1'b1;
      end
      ST_E_CMP: begin
        alu_b   = UW'(best_q);
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign alu_b_eff = alu_sub ? ~alu_b : alu_b;
  assign alu_y     = alu_a + alu_b_eff + {{(UW-1){1'b0}}, alu_sub};

  // first strict minimum wins
  assign win     = !found_q || alu_y[UW-1];
  assign best_nx = win ? acc_q : best_q;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_func)
            FUNC_RUN:     state_d = ST_RUN;
            FUNC_RD_TOUR: state_d = ST_RD;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD:     state_d = ST_DONE;
      ST_RUN:    state_d = (len_q < LW'(4)) ? ST_DONE : ST_S_H;
      ST_S_H:    state_d = ST_S_I;
      ST_S_I:    state_d = ST_S_J;
      ST_S_J:    state_d = ST_S_CHI;
      ST_S_CHI:  state_d = ST_E_L;
      ST_E_L:    state_d = ST_E_HJ;
      ST_E_HJ:   state_d = ST_E_IL;
      ST_E_IL:   state_d = ST_E_JL;
      ST_E_JL:   state_d = ST_E_SUB1;
      ST_E_SUB1: state_d = ST_E_SUB2;
      ST_E_SUB2: state_d = ST_E_CMP;
      ST_E_CMP: begin
        if (more_e) begin
          state_d = ST_E_L;
        end else if (more_s) begin
          state_d = ST_S_H;
        end else if (best_nx[DW-1]) begin
          state_d = ST_REV_A;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_REV_A:  state_d = ST_REV_B;
      ST_REV_B:  state_d = ST_REV_WA;
      ST_REV_WA: state_d = ST_REV_WB;
      ST_REV_WB: state_d = more_rev ? ST_REV_A : ST_DONE;
      ST_DONE:   state_d = (!out_valid_q || m_axis_tready_i) ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);
  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tour_len_q  <= LEN_W'(16);
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tour_len_q <= cfg_data_i;
      end
      if (state_q == ST_RUN) begin
        found_q <= 1'b0;
      end else if (state_q == ST_E_CMP) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          len_q <= (int'(tour_len_q) > MAX_CITIES) ? LW'(MAX_CITIES) : LW'(tour_len_q);
        end
      end
      ST_RD: begin
        res_kind_q <= KIND_READ;
        res_city_q <= tour_rdata;
        best_q     <= '0;
        bs_q       <= '0;
        be_q       <= '0;
        applied_q  <= 1'b0;
      end
      ST_RUN: begin
        res_kind_q <= KIND_RUN;
        res_city_q <= '0;
        best_q     <= '0;
        bs_q       <= '0;
        be_q       <= '0;
        applied_q  <= 1'b0;
        s_q        <= PW'(1);
        e_q        <= PW'(2);
      end
      ST_S_I: h_q <= tour_rdata;
      ST_S_J: i_q <= tour_rdata;
      ST_S_CHI: begin
        j_q   <= tour_rdata;
        chi_q <= cost_rdata;
      end
      ST_E_HJ: l_q <= tour_rdata;
      ST_E_IL, ST_E_JL, ST_E_SUB1, ST_E_SUB2: acc_q <= DW'(alu_y);
      ST_E_CMP: begin
        if (win) begin
          best_q <= acc_q;
          bs_q   <= s_q;
          be_q   <= e_q;
        end
        if (more_e) begin
          e_q <= e_q + PW'(1);
          j_q <= l_q;
        end else if (more_s) begin
          s_q <= s_q + PW'(1);
          e_q <= s_q + PW'(2);
        end else begin
          // scan over: s/e now walk the winning segment inward
          s_q       <= win ? s_q : bs_q;
          e_q       <= win ? e_q : be_q;
          applied_q <= best_nx[DW-1];
        end
      end
      ST_REV_B: h_q <= tour_rdata;
      ST_REV_WB: begin
        s_q <= s_q + PW'(1);
        e_q <= e_q - PW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q            <= res_kind_q;
      out_data_q.pad        <= 1'b0;
      out_data_q.applied    <= applied_q;
      out_data_q.move_end   <= POS_W'(be_q);
      out_data_q.move_start <= POS_W'(bs_q);
      out_data_q.best_delta <= DELTA_W'(best_q);
      out_data_q.city_out   <= res_city_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;

  // ---------------- checks ----------------
  `TOPT_ASSERT_IMPL(a_read_fields_zero, m_axis_tvalid_o && (m_axis_tuser_o == KIND_READ), m_axis_tdata_o[OUT_DATA_W-1:CITY_W] == '0, "tour read result carries run fields")
  `TOPT_ASSERT_IMPL(a_rev_only_negative, state_q == ST_REV_A, best_q < 0, "segment reversal started without a negative delta")
  `TOPT_ASSERT_IMPL(a_rev_bounds, state_q == ST_REV_A, s_q < e_q, "reversal bounds crossed")
  `TOPT_ASSERT_IMPL(a_scan_bounds, state_q == ST_E_L, (e_q > s_q) && ((LW'(e_q) + LW'(1)) < len_q), "segment end outside tour")
  `TOPT_ASSERT_ALWAYS(a_idle_when_ready, !s_axis_tready_o || !found_q || (state_q == ST_IDLE), "sequencer busy while taking requests")

endmodule
